FILE: rtl/core/decimal_to_scaled_fixed_unit_assert.svh
// Assertion macros used by the checker file of the decimal to fixed-point unit.
`ifndef DECIMAL_TO_SCALED_FIXED_UNIT_ASSERT_SVH
`define DECIMAL_TO_SCALED_FIXED_UNIT_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define DSF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define DSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define DSF_ASSERT_RESET(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/dsf_pkg.sv
// Types, character codes and power-of-ten tables for the decimal to fixed-point unit.
package dsf_pkg;

    localparam int unsigned MAG_W   = 63;
    localparam int unsigned SCALE_W = 5;

    localparam logic [7:0]         CH_MINUS    = 8'h2D;
    localparam logic [7:0]         CH_POINT    = 8'h2E;
    localparam logic [7:0]         CH_ZERO     = 8'h30;
    localparam logic [7:0]         CH_NINE     = 8'h39;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd8;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_req;

    typedef struct packed {
        logic signed [63:0] value;
        logic               ok;
    } t_out_req;

    // Largest accumulator that still takes digit d without passing 2^63-1.
    function automatic logic [MAG_W-1:0] digit_limit(input logic [3:0] d);
        logic [MAG_W-1:0] lim;
        if (d > 4'd7) begin
            lim = 63'd922337203685477579;
        end else begin
            lim = 63'd922337203685477580;
        end
        return lim;
    endfunction

    function automatic logic [MAG_W-1:0] pow10(input logic [SCALE_W-1:0] k);
        logic [MAG_W-1:0] p;
        case (k)
            5'd0:    p = 63'd1;
            5'd1:    p = 63'd10;
            5'd2:    p = 63'd100;
            5'd3:    p = 63'd1000;
            5'd4:    p = 63'd10000;
            5'd5:    p = 63'd100000;
            5'd6:    p = 63'd1000000;
            5'd7:    p = 63'd10000000;
            5'd8:    p = 63'd100000000;
            5'd9:    p = 63'd1000000000;
            5'd10:   p = 63'd10000000000;
            5'd11:   p = 63'd100000000000;
            5'd12:   p = 63'd1000000000000;
            5'd13:   p = 63'd10000000000000;
            5'd14:   p = 63'd100000000000000;
            5'd15:   p = 63'd1000000000000000;
            5'd16:   p = 63'd10000000000000000;
            5'd17:   p = 63'd100000000000000000;
            5'd18:   p = 63'd1000000000000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

    // Largest magnitude whose product with 10^k stays at or below 2^63-1.
    function automatic logic [MAG_W-1:0] mag_limit(input logic [SCALE_W-1:0] k);
        logic [MAG_W-1:0] lim;
        case (k)
            5'd0:    lim = 63'd9223372036854775807;
            5'd1:    lim = 63'd922337203685477580;
            5'd2:    lim = 63'd92233720368547758;
            5'd3:    lim = 63'd9223372036854775;
            5'd4:    lim = 63'd922337203685477;
            5'd5:    lim = 63'd92233720368547;
            5'd6:    lim = 63'd9223372036854;
            5'd7:    lim = 63'd922337203685;
            5'd8:    lim = 63'd92233720368;
            5'd9:    lim = 63'd9223372036;
            5'd10:   lim = 63'd922337203;
            5'd11:   lim = 63'd92233720;
            5'd12:   lim = 63'd9223372;
            5'd13:   lim = 63'd922337;
            5'd14:   lim = 63'd92233;
            5'd15:   lim = 63'd9223;
            5'd16:   lim = 63'd922;
            5'd17:   lim = 63'd92;
            5'd18:   lim = 63'd9;
            default: lim = '0;
        endcase
        return lim;
    endfunction

endpackage

FILE: rtl/core/decimal_to_scaled_fixed_unit.sv
// Streaming ASCII decimal to scaled signed 64-bit fixed-point converter.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall    i_in_req  (ch, last)
//   out      output     o_out_valid / i_out_stall  o_out_req (value, ok)
//   cfg      input      i_cfg_we                   i_cfg_wdata (scale_digits)
//
// One character is taken per cycle while o_in_stall is low; the multiply-by-ten accumulator step sets that rate.
// A final character goes from the input register to its result through the
// parse step, partial-product multiply by the power of ten, then sum and sign.
// Reset is synchronous and clears the parse state, the pipeline and scale_digits to 8.
// A stalled result holds the output register while the earlier stages keep filling.
module decimal_to_scaled_fixed_unit
    import dsf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_req            i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_req           o_out_req,
    input  logic               i_cfg_we,
    input  logic [SCALE_W-1:0] i_cfg_wdata
);

    logic [SCALE_W-1:0] r_scale;

    logic     r_in_v;
    t_in_req  r_in;

    logic [MAG_W-1:0]   r_acc,     n_acc;
    logic               r_ovf,     n_ovf;
    logic               r_neg,     n_neg;
    logic               r_first;
    logic               r_frac,    n_frac;
    logic [SCALE_W-1:0] r_fcnt,    n_fcnt;
    logic               r_saw,     n_saw;
    logic               r_failed,  n_failed;

    logic               r_s1_v;
    logic [MAG_W-1:0]   r_s1_mag;
    logic [SCALE_W-1:0] r_s1_k;
    logic               r_s1_neg;
    logic               r_s1_good;

    logic               r_s2_v;
    logic [63:0]        r_s2_lo;
    logic [31:0]        r_s2_cross;
    logic               r_s2_neg;
    logic               r_s2_ok;

    logic               r_out_v;
    t_out_req           r_out;

    logic               w_out_ready, w_s2_ready, w_s1_ready;
    logic               w_consume, w_accept;
    logic               w_is_digit;
    logic [3:0]         w_d;
    logic [MAG_W-1:0]   w_acc_push;
    logic               w_good;
    logic [SCALE_W-1:0] w_k;
    logic [MAG_W-1:0]   w_p;
    logic [63:0]        w_lo;
    logic [63:0]        w_hl;
    logic [63:0]        w_lh;
    logic [63:0]        w_prod;

    assign w_out_ready = !r_out_v || !i_out_stall;
    assign w_s2_ready  = !r_s2_v || w_out_ready;
    assign w_s1_ready  = !r_s1_v || w_s2_ready;
    assign w_consume   = r_in_v && (!r_in.last || w_s1_ready);
    assign o_in_stall  = r_in_v && !w_consume;
    assign w_accept    = i_in_valid && !o_in_stall;

    assign w_d        = r_in.ch[3:0];
    assign w_acc_push = (r_acc << 3) + (r_acc << 1) + {{(MAG_W-4){1'b0}}, w_d};

    always_comb begin
        w_is_digit = (r_in.ch inside {[CH_ZERO:CH_NINE]});
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_neg    = r_neg;
        n_frac   = r_frac;
        n_fcnt   = r_fcnt;
        n_saw    = r_saw;
        n_failed = r_failed;
        if (!r_failed) begin
            if (w_is_digit) begin
                n_saw = 1'b1;
                if (!r_frac || (r_fcnt < r_scale)) begin
                    if (!r_ovf) begin
                        if (r_acc > digit_limit(w_d)) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = w_acc_push;
                        end
                    end
                    if (r_frac) begin
                        n_fcnt = r_fcnt + 5'd1;
                    end
                end else if (w_d != 4'd0) begin
                    n_failed = 1'b1;
                end
            end else if ((r_in.ch == CH_MINUS) && r_first) begin
                n_neg = 1'b1;
            end else if ((r_in.ch == CH_POINT) && !r_frac) begin
                n_frac = 1'b1;
            end else begin
                n_failed = 1'b1;
            end
        end
        w_good = !n_failed && n_saw && !n_ovf;
        w_k    = (n_fcnt < r_scale) ? (r_scale - n_fcnt) : '0;
    end

    assign w_p    = pow10(r_s1_k);
    assign w_lo   = {32'd0, r_s1_mag[31:0]} * {32'd0, w_p[31:0]};
    assign w_hl   = {33'd0, r_s1_mag[62:32]} * {32'd0, w_p[31:0]};
    assign w_lh   = {32'd0, r_s1_mag[31:0]} * {33'd0, w_p[62:32]};
    assign w_prod = {r_s2_lo[63:32] + r_s2_cross, r_s2_lo[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_RESET;
            r_in_v   <= 1'b0;
            r_acc    <= '0;
            r_ovf    <= 1'b0;
            r_neg    <= 1'b0;
            r_first  <= 1'b1;
            r_frac   <= 1'b0;
            r_fcnt   <= '0;
            r_saw    <= 1'b0;
            r_failed <= 1'b0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_in_v <= 1'b1;
            end else if (w_consume) begin
                r_in_v <= 1'b0;
            end
            if (w_consume) begin
                if (r_in.last) begin
                    r_acc    <= '0;
                    r_ovf    <= 1'b0;
                    r_neg    <= 1'b0;
                    r_first  <= 1'b1;
                    r_frac   <= 1'b0;
                    r_fcnt   <= '0;
                    r_saw    <= 1'b0;
                    r_failed <= 1'b0;
                end else begin
                    r_acc    <= n_acc;
                    r_ovf    <= n_ovf;
                    r_neg    <= n_neg;
                    r_first  <= 1'b0;
                    r_frac   <= n_frac;
                    r_fcnt   <= n_fcnt;
                    r_saw    <= n_saw;
                    r_failed <= n_failed;
                end
            end
            if (w_consume && r_in.last) begin
                r_s1_v <= 1'b1;
            end else if (w_s2_ready) begin
                r_s1_v <= 1'b0;
            end
            if (w_s2_ready) begin
                r_s2_v <= r_s1_v;
            end
            if (w_out_ready) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_req;
        end
        if (w_consume && r_in.last) begin
            r_s1_mag  <= n_acc;
            r_s1_k    <= w_k;
            r_s1_neg  <= n_neg;
            r_s1_good <= w_good;
        end
        if (w_s2_ready && r_s1_v) begin
            r_s2_lo    <= w_lo;
            r_s2_cross <= w_hl[31:0] + w_lh[31:0];
            r_s2_neg   <= r_s1_neg;
            r_s2_ok    <= r_s1_good && (r_s1_mag <= mag_limit(r_s1_k));
        end
        if (w_out_ready && r_s2_v) begin
            r_out.ok <= r_s2_ok;
            if (!r_s2_ok) begin
                r_out.value <= '0;
            end else if (r_s2_neg) begin
                r_out.value <= -$signed(w_prod);
            end else begin
                r_out.value <= $signed(w_prod);
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_req   = r_out;

endmodule

FILE: rtl/core/dsf_chk.sv
// Port checker for the decimal to fixed-point unit, bound to the top level.
`include "decimal_to_scaled_fixed_unit_assert.svh"

module dsf_chk
    import dsf_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_req o_out_req
);

    `DSF_ASSERT_RESET(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "Result valid after reset.")

    `DSF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_req), "Stalled result changed.")

    `DSF_ASSERT_SAME(a_no_stall_empty, i_clk, i_rst_n, !o_out_valid, !o_in_stall, "Input stalled with empty output.")

    `DSF_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_out_valid && !o_out_req.ok && !o_in_stall, o_out_req.value == 64'd0, "Failed result carries a value.")

endmodule

bind decimal_to_scaled_fixed_unit dsf_chk u_dsf_chk (.*);
